>>> hw/rtl/pcd_pkg.sv
// Package for the polygon closest-direction core.
// Holds default widths and the state encodings of the top level and the edge unit.
// No dependencies.
package pcd_pkg;

    localparam int PCD_COORD_WIDTH = 32;
    localparam int PCD_FRAC_BITS   = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EDGE1,
        ST_EDGE2,
        ST_EMIT
    } pcd_state_t;

    typedef enum logic [3:0] {
        E_IDLE,
        E_NX,
        E_NY,
        E_DX,
        E_DY,
        E_DEN,
        E_CLASS,
        E_DIV,
        E_OX,
        E_OY,
        E_OW,
        E_SQX,
        E_SQY,
        E_DIST,
        E_DONE
    } pcd_edge_state_t;

endpackage

>>> hw/rtl/pcd_edge_unit.sv
// Edge unit: projects a point onto one segment and returns the vector and squared length.
// One shared registered multiplier and a restoring divider step under a small sequencer.
// Depends on pcd_pkg.
module pcd_edge_unit
    import pcd_pkg::*;
#(
    parameter int COORD_WIDTH = PCD_COORD_WIDTH,
    parameter int FRAC_BITS   = PCD_FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [COORD_WIDTH-1:0]     a_x,
    input  logic signed [COORD_WIDTH-1:0]     a_y,
    input  logic signed [COORD_WIDTH-1:0]     b_x,
    input  logic signed [COORD_WIDTH-1:0]     b_y,
    input  logic signed [COORD_WIDTH-1:0]     p_x,
    input  logic signed [COORD_WIDTH-1:0]     p_y,
    output logic                              done,
    output logic signed [COORD_WIDTH:0]       dir_x,
    output logic signed [COORD_WIDTH:0]       dir_y,
    output logic [2*COORD_WIDTH+2:0]          dist_sq
);

    localparam int DW   = COORD_WIDTH + 1;
    localparam int MW   = (DW > FRAC_BITS + 1) ? DW : FRAC_BITS + 1;
    localparam int PW   = 2 * MW;
    localparam int SW   = 2 * DW + 1;
    localparam int CNTW = $clog2(FRAC_BITS);

    pcd_edge_state_t state_reg, state_next;

    logic signed [DW-1:0]  ex_reg, ey_reg, wx_reg, wy_reg;
    logic signed [DW-1:0]  dx_reg, dy_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [SW-1:0]  acc_reg, num_reg, den_reg;
    logic [SW-1:0]         rem_reg;
    logic [SW-1:0]         dist_reg;
    logic [FRAC_BITS-1:0]  t_reg;
    logic [CNTW-1:0]       cnt_reg;

    logic signed [MW-1:0]  mul_a, mul_b;
    logic signed [SW-1:0]  prod_ext;
    logic signed [SW-1:0]  prod_sum;
    logic signed [PW-1:0]  prod_sh;
    logic signed [DW-1:0]  offset;
    logic [SW-1:0]         rem_shift;
    logic [SW-1:0]         den_u;
    logic                  rem_ge;
    logic                  den_zero, num_nonpos, num_ge;
    logic                  load;

    assign load      = start && (state_reg == E_IDLE || state_reg == E_DONE);
    assign prod_ext  = {{(SW-2*DW){prod_reg[2*DW-1]}}, prod_reg[2*DW-1:0]};
    assign prod_sum  = acc_reg + prod_ext;
    assign prod_sh   = prod_reg >>> FRAC_BITS;
    assign offset    = $signed(prod_sh[DW-1:0]);
    assign den_u     = den_reg;
    assign rem_shift = {rem_reg[SW-2:0], 1'b0};
    assign rem_ge    = rem_shift >= den_u;
    assign den_zero  = den_reg == '0;
    assign num_nonpos = num_reg[SW-1] || num_reg == '0;
    assign num_ge    = num_reg >= den_reg;

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            E_NX: begin
                mul_a = MW'(ex_reg);
                mul_b = MW'(wx_reg);
            end
            E_NY: begin
                mul_a = MW'(ey_reg);
                mul_b = MW'(wy_reg);
            end
            E_DX: begin
                mul_a = MW'(ex_reg);
                mul_b = MW'(ex_reg);
            end
            E_DY: begin
                mul_a = MW'(ey_reg);
                mul_b = MW'(ey_reg);
            end
            E_OX: begin
                mul_a = MW'(ex_reg);
                mul_b = MW'(signed'({1'b0, t_reg}));
            end
            E_OY: begin
                mul_a = MW'(ey_reg);
                mul_b = MW'(signed'({1'b0, t_reg}));
            end
            E_SQX: begin
                mul_a = MW'(dx_reg);
                mul_b = MW'(dx_reg);
            end
            E_SQY: begin
                mul_a = MW'(dy_reg);
                mul_b = MW'(dy_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        done       = 1'b0;
        case (state_reg)
            E_IDLE: begin
                if (start) begin
                    state_next = E_NX;
                end
            end
            E_NX:  state_next = E_NY;
            E_NY:  state_next = E_DX;
            E_DX:  state_next = E_DY;
            E_DY:  state_next = E_DEN;
            E_DEN: state_next = E_CLASS;
            E_CLASS: begin
                if (den_zero || num_nonpos || num_ge) begin
                    state_next = E_SQX;
                end else begin
                    state_next = E_DIV;
                end
            end
            E_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = E_OX;
                end
            end
            E_OX:  state_next = E_OY;
            E_OY:  state_next = E_OW;
            E_OW:  state_next = E_SQX;
            E_SQX: state_next = E_SQY;
            E_SQY: state_next = E_DIST;
            E_DIST: state_next = E_DONE;
            E_DONE: begin
                done       = 1'b1;
                state_next = start ? E_NX : E_IDLE;
            end
            default: state_next = E_IDLE;
        endcase
    end

    // Datapath registers; they follow the sequencer and need no reset.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (load) begin
            ex_reg <= DW'(b_x) - DW'(a_x);
            ey_reg <= DW'(b_y) - DW'(a_y);
            wx_reg <= DW'(p_x) - DW'(a_x);
            wy_reg <= DW'(p_y) - DW'(a_y);
        end
        case (state_reg)
            E_NY:  acc_reg <= prod_ext;
            E_DX:  num_reg <= prod_sum;
            E_DY:  acc_reg <= prod_ext;
            E_DEN: den_reg <= prod_sum;
            E_CLASS: begin
                rem_reg <= num_reg;
                t_reg   <= '0;
                cnt_reg <= CNTW'(FRAC_BITS - 1);
                if (den_zero || num_nonpos) begin
                    dx_reg <= -wx_reg;
                    dy_reg <= -wy_reg;
                end else begin
                    // Parameter clamps to one: nearest point is the far vertex (the divide path overwrites it later).
                    dx_reg <= ex_reg - wx_reg;
                    dy_reg <= ey_reg - wy_reg;
                end
            end
            E_DIV: begin
                rem_reg <= rem_ge ? rem_shift - den_u : rem_shift;
                t_reg   <= {t_reg[FRAC_BITS-2:0], rem_ge};
                cnt_reg <= cnt_reg - 1'b1;
            end
            E_OY:  dx_reg <= offset - wx_reg;
            E_OW:  dy_reg <= offset - wy_reg;
            E_SQY: acc_reg <= prod_ext;
            E_DIST: dist_reg <= prod_sum;
            default: begin
            end
        endcase
    end

    assign dir_x   = dx_reg;
    assign dir_y   = dy_reg;
    assign dist_sq = dist_reg;

endmodule

>>> hw/rtl/polygon_closest_direction_core.sv
// Polygon closest direction: vector from a query point to the nearest boundary point.
// Each request runs its edges one at a time through the edge unit's shared multiplier.
// An edge skips the divider when the projection clamps and runs it bit by bit when it divides.
// A first vertex runs no side, a later one frees the input after one side; a last vertex runs
// two sides (a lone one, one), then the result is registered on m_ and the input opens again.
// Synchronous active-low reset ends any open polygon and clears the result valid flag.
module polygon_closest_direction_core
    import pcd_pkg::*;
#(
    parameter int COORD_WIDTH = PCD_COORD_WIDTH,
    parameter int FRAC_BITS   = PCD_FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_query_x,
    input  logic signed [COORD_WIDTH-1:0] s_query_y,
    input  logic signed [COORD_WIDTH-1:0] s_vertex_x,
    input  logic signed [COORD_WIDTH-1:0] s_vertex_y,
    input  logic                          s_last_vertex,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_dir_x,
    output logic signed [COORD_WIDTH-1:0] m_dir_y
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int SW = 2 * DW + 1;

    pcd_state_t state_reg, state_next;

    logic                          run_active_reg;
    logic                          last_reg;
    logic signed [COORD_WIDTH-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_WIDTH-1:0] prev_x_reg, prev_y_reg;
    logic signed [COORD_WIDTH-1:0] cur_x_reg, cur_y_reg;
    logic signed [COORD_WIDTH-1:0] q_x_reg, q_y_reg;
    logic                          best_valid_reg;
    logic [SW-1:0]                 best_dist_reg;
    logic signed [COORD_WIDTH-1:0] best_dir_x_reg, best_dir_y_reg;
    logic                          m_valid_reg;
    logic signed [COORD_WIDTH-1:0] m_dir_x_reg, m_dir_y_reg;

    logic                          accept;
    logic                          emit;
    logic                          edge_start;
    logic                          edge_done;
    logic signed [COORD_WIDTH-1:0] op_a_x, op_a_y, op_b_x, op_b_y, op_p_x, op_p_y;
    logic signed [DW-1:0]          edge_dx, edge_dy;
    logic [SW-1:0]                 edge_dist;
    logic                          better;
    logic signed [COORD_WIDTH-1:0] sat_dx, sat_dy;

    pcd_edge_unit #(
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_edge (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (edge_start),
        .a_x    (op_a_x),
        .a_y    (op_a_y),
        .b_x    (op_b_x),
        .b_y    (op_b_y),
        .p_x    (op_p_x),
        .p_y    (op_p_y),
        .done   (edge_done),
        .dir_x  (edge_dx),
        .dir_y  (edge_dy),
        .dist_sq(edge_dist)
    );

    assign s_ready = state_reg == ST_IDLE;
    assign accept  = s_valid && s_ready;
    assign emit    = state_reg == ST_EMIT && (!m_valid_reg || m_ready);
    assign better  = edge_done && (!best_valid_reg || edge_dist < best_dist_reg);

    assign sat_dx = (edge_dx[DW-1] != edge_dx[DW-2])
                  ? {edge_dx[DW-1], {(COORD_WIDTH-1){~edge_dx[DW-1]}}}
                  : edge_dx[COORD_WIDTH-1:0];
    assign sat_dy = (edge_dy[DW-1] != edge_dy[DW-2])
                  ? {edge_dy[DW-1], {(COORD_WIDTH-1){~edge_dy[DW-1]}}}
                  : edge_dy[COORD_WIDTH-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // The edge unit samples its operands at start, so the first edge of a request
    // is fed straight from the input ports.
    always_comb begin
        state_next = state_reg;
        edge_start = 1'b0;
        op_a_x     = cur_x_reg;
        op_a_y     = cur_y_reg;
        op_b_x     = first_x_reg;
        op_b_y     = first_y_reg;
        op_p_x     = q_x_reg;
        op_p_y     = q_y_reg;
        case (state_reg)
            ST_IDLE: begin
                op_a_x = run_active_reg ? prev_x_reg : s_vertex_x;
                op_a_y = run_active_reg ? prev_y_reg : s_vertex_y;
                op_b_x = s_vertex_x;
                op_b_y = s_vertex_y;
                op_p_x = s_query_x;
                op_p_y = s_query_y;
                if (accept) begin
                    if (run_active_reg) begin
                        edge_start = 1'b1;
                        state_next = ST_EDGE1;
                    end else if (s_last_vertex) begin
                        // A lone vertex only closes onto itself.
                        edge_start = 1'b1;
                        state_next = ST_EDGE2;
                    end
                end
            end
            ST_EDGE1: begin
                if (edge_done) begin
                    if (last_reg) begin
                        edge_start = 1'b1;
                        state_next = ST_EDGE2;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EDGE2: begin
                if (edge_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cur_x_reg  <= s_vertex_x;
            cur_y_reg  <= s_vertex_y;
            prev_x_reg <= s_vertex_x;
            prev_y_reg <= s_vertex_y;
            q_x_reg    <= s_query_x;
            q_y_reg    <= s_query_y;
            last_reg   <= s_last_vertex;
            if (!run_active_reg) begin
                first_x_reg <= s_vertex_x;
                first_y_reg <= s_vertex_y;
            end
        end
        if (better) begin
            best_dist_reg  <= edge_dist;
            best_dir_x_reg <= sat_dx;
            best_dir_y_reg <= sat_dy;
        end
        if (emit) begin
            m_dir_x_reg <= best_dir_x_reg;
            m_dir_y_reg <= best_dir_y_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_active_reg <= 1'b0;
            best_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                run_active_reg <= 1'b1;
            end
            if (better) begin
                best_valid_reg <= 1'b1;
            end
            if (emit) begin
                run_active_reg <= 1'b0;
                best_valid_reg <= 1'b0;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_dir_x = m_dir_x_reg;
    assign m_dir_y = m_dir_y_reg;

endmodule
